@@ src/gfmi_pkg.sv @@
// shared constants, types and helpers of the gf(2^8) multiply and inverse unit
package gfmi_pkg;

    localparam int ByteW     = 8;
    localparam int PolyW     = 9;
    localparam int CoefW     = 16;
    localparam int DegW      = 4;
    localparam int StepLimit = 40;
    localparam int StepW     = $clog2(StepLimit + 1);
    localparam int BitCntW   = $clog2(ByteW);

    localparam logic [PolyW-1:0] PolyReset = 9'h11B;
    localparam logic [ByteW-1:0] TopBit    = 8'h80;

    localparam logic [1:0] KIND_ADD = 2'd0;
    localparam logic [1:0] KIND_MUL = 2'd1;
    localparam logic [1:0] KIND_INV = 2'd2;

    typedef enum logic [1:0]
    {
        STAT_OK,
        STAT_NO_INVERSE,
        STAT_REDUCIBLE
    } status_t;

    typedef struct packed
    {
        logic             done;
        logic [ByteW-1:0] value;
        status_t          status;
    } gfmi_res_t;

    function automatic logic [DegW-1:0] poly_degree(input logic [PolyW-1:0] p);
        logic [DegW-1:0] d;
        d = '0;
        for (int i = 0; i < PolyW; i++)
        begin
            if (p[i])
            begin
                d = DegW'(i);
            end
        end
        return d;
    endfunction

endpackage

@@ src/gfmi_in_if.sv @@
// operation channel: kind and two operand bytes
interface gfmi_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] operand_a;
    logic [7:0] operand_b;

    modport source (output valid, output kind, output operand_a, output operand_b, input ready);
    modport sink   (input valid, input kind, input operand_a, input operand_b, output ready);
endinterface

@@ src/gfmi_out_if.sv @@
// result channel: value byte and status
interface gfmi_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] value;
    logic [1:0] status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

@@ src/gfmi_mul_serial.sv @@
// bit-serial shift-and-add multiplier with reduction by the low polynomial byte
module gfmi_mul_serial
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [gfmi_pkg::ByteW-1:0]    a,
    input  logic [gfmi_pkg::ByteW-1:0]    b,
    input  logic [gfmi_pkg::ByteW-1:0]    poly_low,
    output gfmi_pkg::gfmi_res_t           res
);
    import gfmi_pkg::*;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [ByteW-1:0]   a_reg, a_next;
    logic [ByteW-1:0]   b_reg, b_next;
    logic [ByteW-1:0]   acc_reg, acc_next;
    logic [BitCntW-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            a_next    = a;
            b_next    = b;
            acc_next  = '0;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_next = acc_reg ^ a_reg;
            end
            if ((a_reg & TopBit) != '0)
            begin
                a_next = (a_reg << 1) ^ poly_low;
            end
            else
            begin
                a_next = a_reg << 1;
            end
            b_next   = b_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == BitCntW'(ByteW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            a_reg    <= '0;
            b_reg    <= '0;
            acc_reg  <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            a_reg    <= a_next;
            b_reg    <= b_next;
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign res = '{done: done_reg, value: acc_reg, status: STAT_OK};

endmodule

@@ src/gfmi_euclid.sv @@
// extended euclid inverse, one polynomial reduction step per cycle
module gfmi_euclid
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [gfmi_pkg::ByteW-1:0]    a,
    input  logic [gfmi_pkg::PolyW-1:0]    poly,
    output gfmi_pkg::gfmi_res_t           res
);
    import gfmi_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [PolyW-1:0] r0_reg, r0_next, r1_reg, r1_next;
    logic [CoefW-1:0] s0_reg, s0_next, s1_reg, s1_next;
    logic [StepW-1:0] step_reg, step_next;
    logic [ByteW-1:0] value_reg, value_next;
    status_t          status_reg, status_next;

    logic [DegW-1:0]  d0, d1, k;
    logic             swap, running;
    logic [PolyW-1:0] r_hi, r_lo, g;
    logic [CoefW-1:0] s_hi, s_lo, sg;

    always_comb
    begin
        d0      = poly_degree(r0_reg);
        d1      = poly_degree(r1_reg);
        swap    = d0 < d1;
        r_hi    = swap ? r1_reg : r0_reg;
        r_lo    = swap ? r0_reg : r1_reg;
        s_hi    = swap ? s1_reg : s0_reg;
        s_lo    = swap ? s0_reg : s1_reg;
        k       = swap ? (d1 - d0) : (d0 - d1);
        running = (step_reg != StepW'(StepLimit)) && (r0_reg != '0) && (r1_reg != '0);
        g       = (r0_reg != '0) ? r0_reg : r1_reg;
        sg      = (r0_reg != '0) ? s0_reg : s1_reg;

        busy_next   = busy_reg;
        done_next   = 1'b0;
        r0_next     = r0_reg;
        r1_next     = r1_reg;
        s0_next     = s0_reg;
        s1_next     = s1_reg;
        step_next   = step_reg;
        value_next  = value_reg;
        status_next = status_reg;

        if (start)
        begin
            if (a == '0)
            begin
                done_next   = 1'b1;
                value_next  = '0;
                status_next = STAT_NO_INVERSE;
            end
            else
            begin
                busy_next = 1'b1;
                r0_next   = poly;
                r1_next   = {1'b0, a};
                s0_next   = '0;
                s1_next   = CoefW'(1);
                step_next = '0;
            end
        end
        else if (busy_reg)
        begin
            if (running)
            begin
                r0_next   = r_hi ^ (r_lo << k);
                r1_next   = r_lo;
                s0_next   = s_hi ^ (s_lo << k);
                s1_next   = s_lo;
                step_next = step_reg + 1'b1;
            end
            else
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (g == PolyW'(1))
                begin
                    value_next  = sg[ByteW-1:0];
                    status_next = STAT_OK;
                end
                else
                begin
                    value_next  = '0;
                    status_next = STAT_REDUCIBLE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            r0_reg     <= '0;
            r1_reg     <= '0;
            s0_reg     <= '0;
            s1_reg     <= '0;
            step_reg   <= '0;
            value_reg  <= '0;
            status_reg <= STAT_OK;
        end
        else
        begin
            busy_reg   <= busy_next;
            done_reg   <= done_next;
            r0_reg     <= r0_next;
            r1_reg     <= r1_next;
            s0_reg     <= s0_next;
            s1_reg     <= s1_next;
            step_reg   <= step_next;
            value_reg  <= value_next;
            status_reg <= status_next;
        end
    end

    assign res = '{done: done_reg, value: value_reg, status: status_reg};

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= StepW'(StepLimit))
        else $error("euclid step count beyond limit");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && done_reg))
        else $error("euclid done while still busy");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (status_reg != STAT_OK) |-> value_reg == '0)
        else $error("euclid error result with nonzero value");

endmodule

@@ src/gf256_multiply_inverse_unit.sv @@
// top level of the gf(2^8) add, multiply and inverse unit
//
// one operation word in on the operation channel (kind, operand_a, operand_b),
// one result word out on the result channel (value, status), valid/ready on both
// field_polynomial is written through cfg_we/cfg_wdata, and the user must write
// it only while the unit is idle; the unit itself does not enforce this
// add and the unused kind reach the output register via the core result register
// multiply walks operand_b one bit per cycle, in 8 steps
// inverse runs one euclid reduction step per cycle: at most 16 steps, set by the
// degrees of the polynomial and operand, and none for a zero operand
// one word is worked on at a time; the next is taken once the result has moved
// to the output register, so a word can be accepted while a result waits there
// a stalled receiver holds the result in the output register and, behind it,
// the finished result in the core, after which operation.ready stays low
// reset empties both registers, drops any word in flight and loads 0x11b
module gf256_multiply_inverse_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [gfmi_pkg::PolyW-1:0]    cfg_wdata,
    gfmi_in_if.sink                       operation,
    gfmi_out_if.source                    result
);
    import gfmi_pkg::*;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_BUSY,
        S_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [PolyW-1:0] poly_reg, poly_next;
    logic [ByteW-1:0] res_value_reg, res_value_next;
    status_t          res_status_reg, res_status_next;
    logic             out_valid_reg, out_valid_next;
    logic [ByteW-1:0] out_value_reg, out_value_next;
    status_t          out_status_reg, out_status_next;

    logic      accept;
    logic      mul_start, inv_start;
    gfmi_res_t mul_res, inv_res;

    assign operation.ready = (state_reg == S_IDLE);
    assign accept          = operation.valid && operation.ready;
    assign mul_start       = accept && (operation.kind == KIND_MUL);
    assign inv_start       = accept && (operation.kind == KIND_INV);

    gfmi_mul_serial u_mul
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mul_start),
        .a        (operation.operand_a),
        .b        (operation.operand_b),
        .poly_low (poly_reg[ByteW-1:0]),
        .res      (mul_res)
    );

    gfmi_euclid u_inv
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (inv_start),
        .a     (operation.operand_a),
        .poly  (poly_reg),
        .res   (inv_res)
    );

    always_comb
    begin
        state_next      = state_reg;
        poly_next       = cfg_we ? cfg_wdata : poly_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (operation.kind) inside
                        KIND_ADD:
                        begin
                            res_value_next  = operation.operand_a ^ operation.operand_b;
                            res_status_next = STAT_OK;
                            state_next      = S_DONE;
                        end
                        KIND_MUL, KIND_INV:
                        begin
                            state_next = S_BUSY;
                        end
                        default:
                        begin
                            res_value_next  = '0;
                            res_status_next = STAT_OK;
                            state_next      = S_DONE;
                        end
                    endcase
                end
            end
            S_BUSY:
            begin
                if (mul_res.done)
                begin
                    res_value_next  = mul_res.value;
                    res_status_next = mul_res.status;
                    state_next      = S_DONE;
                end
                else if (inv_res.done)
                begin
                    res_value_next  = inv_res.value;
                    res_status_next = inv_res.status;
                    state_next      = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = res_value_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            poly_reg       <= PolyReset;
            res_value_reg  <= '0;
            res_status_reg <= STAT_OK;
            out_valid_reg  <= 1'b0;
            out_value_reg  <= '0;
            out_status_reg <= STAT_OK;
        end
        else
        begin
            state_reg      <= state_next;
            poly_reg       <= poly_next;
            res_value_reg  <= res_value_next;
            res_status_reg <= res_status_next;
            out_valid_reg  <= out_valid_next;
            out_value_reg  <= out_value_next;
            out_status_reg <= out_status_next;
        end
    end

    assign result.valid  = out_valid_reg;
    assign result.value  = out_value_reg;
    assign result.status = out_status_reg;

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("accepted word did not leave idle");

    a_done_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (mul_res.done || inv_res.done) |-> state_reg == S_BUSY)
        else $error("unit finished outside busy state");

    a_single_done: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_res.done && inv_res.done))
        else $error("multiplier and inverse finished together");

    a_error_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_status_reg != STAT_OK) |-> out_value_reg == '0)
        else $error("error result with nonzero value");

endmodule
